// File: design/iss_pkg.sv
// Shared types, codes and field widths for the indexed stack store.
`default_nettype none

package iss_pkg;

    // Default geometry of the element store.
    localparam int DEPTH_DEF = 1024;
    localparam int WIDTH_DEF = 32;

    // Field widths of the command and result beats.
    localparam int CMD_W     = 3;
    localparam int VALUE_W   = 32;
    localparam int INDEX_W   = 10;
    localparam int COUNT_W   = 11;
    localparam int RDATA_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int FILL_W    = 11;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 3'd0,
        CMD_POP   = 3'd1,
        CMD_READ  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_TOP   = 3'd4,
        CMD_CLEAR = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // One decoded command on its way from the control stage to the result stage.
    typedef struct packed {
        logic              valid;
        logic              rd;
        t_status           status;
        logic [FILL_W-1:0] fill;
    } t_op;

endpackage

`default_nettype wire

// File: design/iss_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module iss_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [W-1:0]             i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: design/iss_ctrl.sv
// Command decode, fill-count register and memory access issue.
`default_nettype none

module iss_ctrl #(
    parameter int DEPTH = iss_pkg::DEPTH_DEF,
    parameter int WIDTH = iss_pkg::WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic [iss_pkg::CMD_W-1:0]    i_cmd,
    input  wire logic [iss_pkg::VALUE_W-1:0]  i_value,
    input  wire logic [iss_pkg::INDEX_W-1:0]  i_index,
    input  wire logic [iss_pkg::COUNT_W-1:0]  i_count,
    input  wire logic                         i_dn_ready,
    output iss_pkg::t_op                      o_op,
    output logic                              o_we,
    output logic      [$clog2(DEPTH)-1:0]     o_waddr,
    output logic      [WIDTH-1:0]             o_wdata,
    output logic                              o_re,
    output logic      [$clog2(DEPTH)-1:0]     o_raddr
);

    import iss_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (CW > COUNT_W) ? CW : COUNT_W;

    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             accept;
    logic [CMP_W-1:0] cnt_w;
    logic [CMP_W-1:0] idx_w;
    logic [CMP_W-1:0] pop_w;
    logic             idx_ok;
    logic             we;
    logic             re;
    t_status          status;

    assign accept = i_valid && i_dn_ready;
    assign cnt_w  = CMP_W'(r_count);
    assign idx_w  = CMP_W'(i_index);
    assign pop_w  = CMP_W'(i_count);
    // The count never exceeds the depth, so this also keeps the index in range.
    assign idx_ok = idx_w < cnt_w;

    always_comb begin
        n_count = r_count;
        status  = ST_OK;
        we      = 1'b0;
        re      = 1'b0;
        o_waddr = AW'(i_index);
        o_raddr = AW'(i_index);
        case (i_cmd)
            CMD_PUSH: begin
                o_waddr = AW'(r_count);
                if (r_count >= CW'(DEPTH)) begin
                    status = ST_FULL;
                end else begin
                    we      = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            CMD_POP: begin
                if (pop_w > cnt_w) begin
                    status = ST_EMPTY;
                end else begin
                    n_count = CW'(cnt_w - pop_w);
                end
            end
            CMD_READ: begin
                if (idx_ok) begin
                    re = 1'b1;
                end else begin
                    status = ST_RANGE;
                end
            end
            CMD_WRITE: begin
                if (idx_ok) begin
                    we = 1'b1;
                end else begin
                    status = ST_RANGE;
                end
            end
            CMD_TOP: begin
                o_raddr = AW'(r_count - CW'(1));
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end else begin
                    re = 1'b1;
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= n_count;
        end
    end

    assign o_we    = accept && we;
    assign o_re    = accept && re;
    assign o_wdata = WIDTH'(i_value);

    assign o_op = '{valid: accept, rd: re, status: status, fill: FILL_W'(n_count)};

endmodule

`default_nettype wire

// File: design/iss_out.sv
// Memory-read stage and output register of the result channel.
`default_nettype none

module iss_out #(
    parameter int WIDTH = iss_pkg::WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire iss_pkg::t_op                  i_op,
    input  wire logic [WIDTH-1:0]              i_rdata,
    input  wire logic                          i_m_tready,
    output logic                               o_up_ready,
    output logic                               o_m_tvalid,
    output logic      [iss_pkg::RDATA_W-1:0]   o_read_data,
    output logic      [iss_pkg::STATUS_W-1:0]  o_status,
    output logic      [iss_pkg::FILL_W-1:0]    o_fill
);

    import iss_pkg::*;

    t_op                 r_s1;
    logic                r_out_valid;
    logic [RDATA_W-1:0]  r_out_data;
    t_status             r_out_status;
    logic [FILL_W-1:0]   r_out_fill;
    logic                move;

    // The RAM read data holds while the stage waits, since no new read is issued.
    assign move       = r_s1.valid && (!r_out_valid || i_m_tready);
    assign o_up_ready = !r_s1.valid || move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_up_ready) begin
                r_s1 <= i_op;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_data   <= r_s1.rd ? RDATA_W'(i_rdata) : '0;
            r_out_status <= r_s1.status;
            r_out_fill   <= r_s1.fill;
        end
    end

    assign o_m_tvalid  = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_status    = r_out_status;
    assign o_fill      = r_out_fill;

endmodule

`default_nettype wire

// File: design/indexed_stack_store_top.sv
// Top level of the indexed stack store: a stack with random access by index.
//
// Commands arrive as beats on the slave stream; the command code travels in
// s_axis_tuser and its operands in s_axis_tdata. Every command produces exactly
// one result beat on the master stream carrying the read data, a status code
// and the fill level after the command.
//
// The elements live in one synchronous RAM with a registered read.
// A command is decoded in the cycle it is accepted: the fill count is updated
// and the RAM write or read is issued at that edge, and the command enters the
// read stage. Once the output register is free, the read data is captured into
// it as the result beat. One command is accepted per cycle while the receiver
// keeps up; since the count is updated at acceptance and each command touches
// at most one RAM entry, back-to-back accesses to one entry need no forwarding.
//
// When the receiver stalls, the output register holds its beat and one more
// command can sit in the read stage; after that s_axis_tready drops until the
// output beat is taken. Reset clears the fill count and both pipeline valids;
// the RAM contents are not cleared and no clearing pass is needed, because only
// entries below the fill level, which were all written, are ever read.
`default_nettype none

module indexed_stack_store_top #(
    parameter int DEPTH = iss_pkg::DEPTH_DEF,
    parameter int WIDTH = iss_pkg::WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // value [31:0], index [41:32], count [52:42], zero fill [55:53]
    input  wire logic [iss_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // command [2:0]
    input  wire logic [iss_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // read_data [31:0], status [33:32], fill_level [44:34], zero fill [47:45]
    output logic      [iss_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    import iss_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_op                 op;
    logic                dn_ready;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [WIDTH-1:0]    wdata;
    logic                re;
    logic [AW-1:0]       raddr;
    logic [WIDTH-1:0]    rdata;
    logic [RDATA_W-1:0]  read_data;
    logic [STATUS_W-1:0] status;
    logic [FILL_W-1:0]   fill;

    // Decode and count update happen in the acceptance cycle.
    iss_ctrl #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .i_cmd      (s_axis_tuser),
        .i_value    (s_axis_tdata[VALUE_W-1:0]),
        .i_index    (s_axis_tdata[VALUE_W +: INDEX_W]),
        .i_count    (s_axis_tdata[VALUE_W + INDEX_W +: COUNT_W]),
        .i_dn_ready (dn_ready),
        .o_op       (op),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_re       (re),
        .o_raddr    (raddr)
    );

    // Element store.
    iss_ram #(
        .W     (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Read stage and output register.
    iss_out #(
        .WIDTH (WIDTH)
    ) u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_rdata     (rdata),
        .i_m_tready  (m_axis_tready),
        .o_up_ready  (dn_ready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_read_data (read_data),
        .o_status    (status),
        .o_fill      (fill)
    );

    assign s_axis_tready = dn_ready;
    assign m_axis_tdata  = {{(M_TDATA_W - RDATA_W - STATUS_W - FILL_W){1'b0}},
                            fill, status, read_data};

endmodule

`default_nettype wire

// File: design/iss_checker.sv
// Port-level checks of the indexed stack store and their binding to the top level.
`default_nettype none

module iss_checker #(
    parameter int DEPTH = iss_pkg::DEPTH_DEF
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [iss_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    import iss_pkg::*;

    logic [RDATA_W-1:0]  read_data;
    logic [STATUS_W-1:0] status;
    logic [FILL_W-1:0]   fill;

    assign read_data = m_axis_tdata[RDATA_W-1:0];
    assign status    = m_axis_tdata[RDATA_W +: STATUS_W];
    assign fill      = m_axis_tdata[RDATA_W + STATUS_W +: FILL_W];

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // No result beat right after reset.
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A failed command never returns data.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && status != ST_OK |-> read_data == '0)
        else $error("read data nonzero on error");

    // Overflow is only reported when the store is full.
    a_full_lvl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && status == ST_FULL |-> fill == FILL_W'(DEPTH))
        else $error("overflow reported below capacity");

    // The fill level never exceeds the capacity.
    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (DEPTH > 2047) || (int'(fill) <= DEPTH))
        else $error("fill level above capacity");

endmodule

bind indexed_stack_store_top iss_checker #(
    .DEPTH (DEPTH)
) u_iss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
